// ===== design/mru_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mru_pkg
// Shared types and constants for the most-recently-used key list.
// ----------------------------------------------------------------------------
package mru_pkg;

    // Default list geometry
    localparam int LIST_DEPTH_DEF = 10;
    localparam int KEY_WIDTH_DEF  = 32;

    // Request modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Request payload
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [3:0]  index;
    } t_req;

    // Result payload
    typedef struct packed {
        logic        hit;
        logic [3:0]  hit_position;
        logic [31:0] entry_key;
        logic        entry_valid;
        logic [3:0]  entry_count;
    } t_res;

    // Handshake between output stage and sequencer
    typedef struct packed {
        logic start;     // request accepted this cycle
        logic res_free;  // output register can take a result
    } t_ctl_in;

    typedef struct packed {
        logic busy;      // sequencer working on a request
        logic done;      // result handed over this cycle
    } t_ctl_out;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_FINAL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== design/mru_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mru_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/mru_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mru_ctrl
// Sequencer for the list: scans the key RAM one slot at a time through a
// single comparator, then shifts slots one move at a time through the RAM.
// The list stays packed, so a fill count stands in for per-slot valid bits.
// ----------------------------------------------------------------------------
module mru_ctrl #(
    parameter int LIST_DEPTH = mru_pkg::LIST_DEPTH_DEF,
    parameter int KEY_WIDTH  = mru_pkg::KEY_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mru_pkg::t_ctl_in  i_ctl,
    input  wire mru_pkg::t_req     i_req,
    output      mru_pkg::t_ctl_out o_stat,
    output      mru_pkg::t_res     o_res
);

    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    // State
    mru_pkg::t_state r_state, n_state;
    logic [1:0]           r_mode, n_mode;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [CW-1:0]        r_count, n_count;
    logic [PW-1:0]        r_ptr, n_ptr;
    logic                 r_hit, n_hit;
    logic [PW-1:0]        r_pos, n_pos;
    logic [KEY_WIDTH-1:0] r_ekey, n_ekey;
    logic                 r_evalid, n_evalid;

    // RAM port signals
    logic                 ram_we;
    logic [PW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic                 ram_re;
    logic [PW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    // Helpers
    logic          is_add;
    logic          key_match;
    logic [CW-1:0] ptr_ext;
    logic [PW-1:0] miss_last;

    mru_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_add    = (r_mode == mru_pkg::MODE_ADD);
    // shared key comparator
    assign key_match = (ram_rdata == r_key);
    assign ptr_ext   = CW'(r_ptr);
    // on an add miss, the deepest slot that takes a shifted key
    assign miss_last = (r_count == CW'(LIST_DEPTH)) ? PW'(LIST_DEPTH - 1) : PW'(r_count);

    // Next state and RAM control
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_hit     = r_hit;
        n_pos     = r_pos;
        n_ekey    = r_ekey;
        n_evalid  = r_evalid;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_ptr;
        o_stat.busy = (r_state != mru_pkg::ST_IDLE);
        o_stat.done = 1'b0;

        unique case (r_state)
            mru_pkg::ST_IDLE: begin
                if (i_ctl.start) begin
                    n_mode   = i_req.mode;
                    n_key    = KEY_WIDTH'(i_req.key);
                    n_hit    = 1'b0;
                    n_pos    = '0;
                    n_ekey   = '0;
                    n_evalid = 1'b0;
                    n_ptr    = '0;
                    unique case (i_req.mode)
                        mru_pkg::MODE_ADD: begin
                            // empty list: straight to the front write
                            n_state = (r_count == '0) ? mru_pkg::ST_FINAL
                                                      : mru_pkg::ST_SCAN_RD;
                        end
                        mru_pkg::MODE_REMOVE: begin
                            n_state = (r_count == '0) ? mru_pkg::ST_DONE
                                                      : mru_pkg::ST_SCAN_RD;
                        end
                        mru_pkg::MODE_READ: begin
                            // slots at or past the count are empty and report a zero key, not valid
                            if (32'(i_req.index) < 32'(r_count)) begin
                                ram_re    = 1'b1;
                                ram_raddr = PW'(i_req.index);
                                n_state   = mru_pkg::ST_READ;
                            end else begin
                                n_state = mru_pkg::ST_DONE;
                            end
                        end
                        default: begin
                            n_state = mru_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            mru_pkg::ST_READ: begin
                n_ekey   = ram_rdata;
                n_evalid = 1'b1;
                n_state  = mru_pkg::ST_DONE;
            end

            mru_pkg::ST_SCAN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_ptr;
                n_state   = mru_pkg::ST_SCAN_CMP;
            end

            mru_pkg::ST_SCAN_CMP: begin
                if (key_match) begin
                    n_hit = 1'b1;
                    n_pos = r_ptr;
                    if (is_add) begin
                        // already at the front: nothing moves
                        n_state = (r_ptr == '0) ? mru_pkg::ST_DONE : mru_pkg::ST_MOVE_RD;
                    end else begin
                        n_state = (ptr_ext == r_count - CW'(1)) ? mru_pkg::ST_FINAL
                                                                : mru_pkg::ST_MOVE_RD;
                    end
                end else if (ptr_ext == r_count - CW'(1)) begin
                    // end of the valid slots, no match
                    if (is_add) begin
                        n_ptr   = miss_last;
                        n_state = mru_pkg::ST_MOVE_RD;
                    end else begin
                        n_state = mru_pkg::ST_DONE;
                    end
                end else begin
                    n_ptr   = r_ptr + PW'(1);
                    n_state = mru_pkg::ST_SCAN_RD;
                end
            end

            mru_pkg::ST_MOVE_RD: begin
                // add shifts toward the tail, remove pulls toward the head
                ram_re    = 1'b1;
                ram_raddr = is_add ? (r_ptr - PW'(1)) : (r_ptr + PW'(1));
                n_state   = mru_pkg::ST_MOVE_WR;
            end

            mru_pkg::ST_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = ram_rdata;
                if (is_add) begin
                    if (r_ptr == PW'(1)) begin
                        n_state = mru_pkg::ST_FINAL;
                    end else begin
                        n_ptr   = r_ptr - PW'(1);
                        n_state = mru_pkg::ST_MOVE_RD;
                    end
                end else begin
                    if (ptr_ext + CW'(2) == r_count) begin
                        n_state = mru_pkg::ST_FINAL;
                    end else begin
                        n_ptr   = r_ptr + PW'(1);
                        n_state = mru_pkg::ST_MOVE_RD;
                    end
                end
            end

            mru_pkg::ST_FINAL: begin
                ram_we = 1'b1;
                if (is_add) begin
                    ram_waddr = '0;
                    ram_wdata = r_key;
                    if (!r_hit && (r_count != CW'(LIST_DEPTH))) begin
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    // clear the vacated tail slot
                    ram_waddr = PW'(r_count - CW'(1));
                    ram_wdata = '0;
                    n_count   = r_count - CW'(1);
                end
                n_state = mru_pkg::ST_DONE;
            end

            mru_pkg::ST_DONE: begin
                if (i_ctl.res_free) begin
                    o_stat.done = 1'b1;
                    n_state     = mru_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = mru_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mru_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_ptr    <= n_ptr;
        r_hit    <= n_hit;
        r_pos    <= n_pos;
        r_ekey   <= n_ekey;
        r_evalid <= n_evalid;
    end

    // Result
    assign o_res.hit          = r_hit;
    assign o_res.hit_position = 4'(r_pos);
    assign o_res.entry_key    = 32'(r_ekey);
    assign o_res.entry_valid  = r_evalid;
    assign o_res.entry_count  = 4'(r_count);

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= LIST_DEPTH)
        else $error("fill count beyond list depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> (r_state == mru_pkg::ST_IDLE))
        else $error("sequencer not idle after handing over a result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.done && r_hit && is_add) |-> (CW'(r_pos) < r_count))
        else $error("add hit reported outside the valid slots");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mru_pkg::ST_SCAN_CMP) |-> (ptr_ext < r_count))
        else $error("scan ran past the valid slots");

endmodule
`default_nettype wire

// ===== design/mru_move_to_front_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mru_move_to_front_list
// Most-recently-used list of keys, slot 0 newest, with add/promote, remove
// and read requests, one result per request.
// Steps: a read fetches its slot from the key RAM, none past the fill count;
//   add and remove scan from slot 0 and stop at a match, then move slots one
//   at a time and write the key to the front or clear the tail slot (nothing
//   moves or is written on a front hit or a remove miss); an unused mode returns an empty result.
// Throughput: one request at a time, the next taken the cycle after the
//   result is registered; set by the single key comparator and the one
//   read / one write port of the key RAM. An output stall holds the sequencer.
// Reset: fill count cleared, list empty; RAM keys are not cleared, since
//   slots past the count are never read and report as empty.
// ----------------------------------------------------------------------------
module mru_move_to_front_list #(
    parameter int LIST_DEPTH = mru_pkg::LIST_DEPTH_DEF,
    parameter int KEY_WIDTH  = mru_pkg::KEY_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_stall,
    input  wire mru_pkg::t_req i_in_req,
    output      logic          o_out_valid,
    input  wire logic          i_out_stall,
    output      mru_pkg::t_res o_out_res
);

    mru_pkg::t_ctl_in  ctl_in;
    mru_pkg::t_ctl_out ctl_out;
    mru_pkg::t_res     ctl_res;

    logic          r_out_valid;
    mru_pkg::t_res r_out_res;

    // Request side: accepted only while the sequencer is idle
    assign o_in_stall      = ctl_out.busy;
    assign ctl_in.start    = i_in_valid && !ctl_out.busy;
    assign ctl_in.res_free = !r_out_valid || !i_out_stall;

    mru_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_req   (i_in_req),
        .o_stat  (ctl_out),
        .o_res   (ctl_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl_out.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_out.done) begin
            r_out_res <= ctl_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_in.start |=> o_in_stall)
        else $error("accepted request did not make the block busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_out.done |-> !(r_out_valid && i_out_stall))
        else $error("result overwrote a pending result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_res)))
        else $error("stalled result changed or dropped");

endmodule
`default_nettype wire
